@@ rtl/okvt_pkg.sv @@
// Shared types and constants for the ordered key/value table.
// Holds the transfer structs, operation and status codes, and cell control.
// No dependencies.
`timescale 1ns / 1ps

package okvt_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_SET     = 3'd1;
  localparam logic [2:0] OP_GET     = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;
  localparam logic [2:0] OP_READ_AT = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [2:0]             operation;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [IDX_W-1:0]       position;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic [KEY_WIDTH-1:0]   key_out;
    logic [VALUE_WIDTH-1:0] value_out;
    logic [CNT_W-1:0]       entry_count;
    logic [1:0]             status;
  } rsp_t;

  // Broadcast to every cell for one accepted transfer.
  typedef struct packed {
    logic del;
    logic upd;
    logic app;
  } cell_ctrl_t;

endpackage

@@ rtl/okvt_cell.sv @@
// One entry of the ordered key/value table: key and value registers,
// key compare, and the hand-off from the next cell on delete. Uses okvt_pkg.
`timescale 1ns / 1ps

module okvt_cell (
  input  logic                            clk,
  input  okvt_pkg::cell_ctrl_t            ctrl,
  input  logic [okvt_pkg::KEY_WIDTH-1:0]   in_key,
  input  logic [okvt_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic [okvt_pkg::KEY_WIDTH-1:0]   nb_key,
  input  logic [okvt_pkg::VALUE_WIDTH-1:0] nb_value,
  input  logic                            occupied,
  input  logic                            tail,
  input  logic                            seen_in,
  output logic [okvt_pkg::KEY_WIDTH-1:0]   key,
  output logic [okvt_pkg::VALUE_WIDTH-1:0] value,
  output logic                            match,
  output logic                            seen_out
);
  import okvt_pkg::*;

  logic [KEY_WIDTH-1:0]   entry_key;
  logic [VALUE_WIDTH-1:0] entry_value;

  assign match    = occupied && (entry_key == in_key);
  assign seen_out = seen_in || match;
  assign key      = entry_key;
  assign value    = entry_value;

  always_ff @(posedge clk) begin
    priority if (ctrl.del && seen_out) begin
      // take the neighbor's entry to close the gap
      entry_key   <= nb_key;
      entry_value <= nb_value;
    end else if (ctrl.upd && match) begin
      entry_value <= in_value;
    end else if (ctrl.app && tail) begin
      entry_key   <= in_key;
      entry_value <= in_value;
    end else begin
      entry_key   <= entry_key;
      entry_value <= entry_value;
    end
  end

endmodule

@@ rtl/ordered_key_value_table.sv @@
// Ordered key/value table of CAPACITY entries kept in insertion order.
// Top level: a chain of okvt_cell entries, entry count and result register.
// Uses okvt_pkg and okvt_cell.
//
// Request channel (req, req_valid, req_stall): one operation per transfer
// (write, set, get, delete, clear, read_at) with key, value and position.
// Response channel (rsp, rsp_valid, rsp_stall): exactly one result per
// request, in order, with found flag, key, value, entry count and status.
// The result appears in the response register on the cycle after the
// request transfer. Throughput is one request per cycle while req_stall
// is low; all cells compare the key at once and a delete moves every
// later cell down by one in the same cycle, so the cell compare plus
// first-match chain sets the cycle time.
// A request is taken while the response register is empty or being drained
// in the same cycle; while the receiver stalls a held response, req_stall
// is high and the response holds.
// Reset empties the table and the response register; entry contents are
// not cleared and are never read before they are written.
`timescale 1ns / 1ps

module ordered_key_value_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  okvt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output okvt_pkg::rsp_t rsp
);
  import okvt_pkg::*;

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   take;
  logic                   hit;
  logic                   full;
  cell_ctrl_t             ctrl;
  rsp_t                   rsp_next;
  logic [VALUE_WIDTH-1:0] hit_value;

  logic [KEY_WIDTH-1:0]   keys   [CAPACITY];
  logic [VALUE_WIDTH-1:0] values [CAPACITY];
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    occupied;
  logic [CAPACITY-1:0]    tail;
  logic [CAPACITY:0]      seen;

  assign req_stall = rsp_valid && rsp_stall;
  assign take      = req_valid && !req_stall;
  assign seen[0]   = 1'b0;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int NB = (i + 1 < CAPACITY) ? i + 1 : i;

      assign occupied[i] = CNT_W'(i) < count;
      assign tail[i]     = CNT_W'(i) == count;

      okvt_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .in_key   (req.key),
        .in_value (req.value),
        .nb_key   (keys[NB]),
        .nb_value (values[NB]),
        .occupied (occupied[i]),
        .tail     (tail[i]),
        .seen_in  (seen[i]),
        .key      (keys[i]),
        .value    (values[i]),
        .match    (match[i]),
        .seen_out (seen[i+1])
      );
    end
  endgenerate

  assign hit  = |match;
  assign full = count == CNT_W'(CAPACITY);

  // occupied keys are unique, so at most one cell matches
  always_comb begin
    hit_value = '0;
    for (int n = 0; n < CAPACITY; n++) begin
      hit_value = hit_value | (match[n] ? values[n] : '0);
    end
  end

  always_comb begin
    ctrl       = '0;
    count_next = count;
    rsp_next   = '0;
    unique case (req.operation)
      OP_WRITE: begin
        rsp_next.found = hit;
        if (hit) begin
          ctrl.upd = take;
        end else if (!full) begin
          ctrl.app   = take;
          count_next = count + CNT_W'(1);
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      OP_SET: begin
        rsp_next.found  = hit;
        ctrl.upd        = take;
        rsp_next.status = hit ? ST_OK : ST_MISSING;
      end
      OP_GET: begin
        rsp_next.found     = hit;
        rsp_next.value_out = hit_value;
        rsp_next.status    = hit ? ST_OK : ST_MISSING;
      end
      OP_DELETE: begin
        rsp_next.found  = hit;
        rsp_next.status = hit ? ST_OK : ST_MISSING;
        if (hit) begin
          ctrl.del   = take;
          count_next = count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      OP_READ_AT: begin
        if ({1'b0, req.position} < count) begin
          rsp_next.found     = 1'b1;
          rsp_next.key_out   = keys[req.position];
          rsp_next.value_out = values[req.position];
        end else begin
          rsp_next.status = ST_MISSING;
        end
      end
      default: begin
      end
    endcase
    rsp_next.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key held in more than one entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    take && req.operation == OP_CLEAR |=> count == '0)
    else $error("clear left entries");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp.entry_count == count)
    else $error("reported count differs from table");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for ordered_key_value_table: directed table, then random operations.
// Checks every response transfer against a fixed result or a prediction from a local table.
// Depends on okvt_pkg and ordered_key_value_table.
`timescale 1ns / 1ps

module testbench;
  import okvt_pkg::*;

  localparam int WATCHDOG  = 5000;
  localparam int RAND_OPS  = 1300;
  localparam int POOL_SIZE = 24;

  typedef struct {
    req_t cmd;
    int   reps;
    bit   fixed;
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  logic row_fixed = 1'b0;
  rsp_t row_want = '0;
  bit   gaps_on = 1'b1;
  bit   stalls_on = 1'b1;

  logic [KEY_WIDTH-1:0]   kv_keys [CAPACITY];
  logic [VALUE_WIDTH-1:0] kv_vals [CAPACITY];
  int                     kv_count = 0;
  logic [KEY_WIDTH-1:0]   key_pool [POOL_SIZE];

  rsp_t      pending_q [$];
  plan_row_t plan [$];
  rsp_t      want_r;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  ordered_key_value_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_stall <= stalls_on && ($urandom_range(99) < 30);
  end

  function automatic rsp_t kv_apply(req_t r);
    rsp_t o;
    int   hit;
    o = '0;
    hit = -1;
    for (int i = 0; i < kv_count; i++) begin
      if (hit < 0 && kv_keys[i] == r.key) hit = i;
    end
    case (r.operation)
      OP_WRITE: begin
        if (hit >= 0) begin
          kv_vals[hit] = r.value;
          o.found = 1'b1;
        end else if (kv_count < CAPACITY) begin
          kv_keys[kv_count] = r.key;
          kv_vals[kv_count] = r.value;
          kv_count++;
        end else begin
          o.status = ST_FULL;
        end
      end
      OP_SET: begin
        if (hit >= 0) begin
          kv_vals[hit] = r.value;
          o.found = 1'b1;
        end else begin
          o.status = ST_MISSING;
        end
      end
      OP_GET: begin
        if (hit >= 0) begin
          o.value_out = kv_vals[hit];
          o.found = 1'b1;
        end else begin
          o.status = ST_MISSING;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          for (int j = hit; j < kv_count - 1; j++) begin
            kv_keys[j] = kv_keys[j + 1];
            kv_vals[j] = kv_vals[j + 1];
          end
          kv_count--;
          o.found = 1'b1;
        end else begin
          o.status = ST_MISSING;
        end
      end
      OP_CLEAR: kv_count = 0;
      OP_READ_AT: begin
        if (int'(r.position) < kv_count) begin
          o.key_out = kv_keys[r.position];
          o.value_out = kv_vals[r.position];
          o.found = 1'b1;
        end else begin
          o.status = ST_MISSING;
        end
      end
      default: ;
    endcase
    o.entry_count = CNT_W'(kv_count);
    return o;
  endfunction

  function automatic void field_check(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        want_r = kv_apply(req);
        if (row_fixed) want_r = row_want;
        pending_q.push_back(want_r);
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: response with nothing outstanding, actual %p", $time, rsp);
          mismatches++;
        end else begin
          want_r = pending_q.pop_front();
          field_check("found", 32'(want_r.found), 32'(rsp.found));
          field_check("key_out", want_r.key_out, rsp.key_out);
          field_check("value_out", want_r.value_out, rsp.value_out);
          field_check("entry_count", 32'(want_r.entry_count), 32'(rsp.entry_count));
          field_check("status", 32'(want_r.status), 32'(rsp.status));
        end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send(req_t cmd, bit fixed, rsp_t want);
    while (gaps_on && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= cmd;
    row_fixed <= fixed;
    row_want  <= want;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic rsp_t outcome(logic f, logic [31:0] ko, logic [31:0] vo,
                                   logic [4:0] cnt, logic [1:0] st);
    rsp_t o;
    o = '{found: f, key_out: ko, value_out: vo, entry_count: cnt, status: st};
    return o;
  endfunction

  function automatic plan_row_t row(logic [2:0] op, logic [31:0] k, logic [31:0] v,
                                    logic [3:0] p, int reps, bit fixed, rsp_t want);
    plan_row_t pr;
    pr.cmd   = '{operation: op, key: k, value: v, position: p};
    pr.reps  = reps;
    pr.fixed = fixed;
    pr.want  = want;
    return pr;
  endfunction

  function automatic req_t random_cmd();
    req_t r;
    int   pick;
    r.key      = ($urandom_range(99) < 8) ? $urandom() : key_pool[$urandom_range(POOL_SIZE - 1)];
    r.value    = $urandom();
    r.position = $urandom_range(15);
    pick = $urandom_range(99);
    if (pick < 35)      r.operation = OP_WRITE;
    else if (pick < 45) r.operation = OP_SET;
    else if (pick < 60) r.operation = OP_GET;
    else if (pick < 74) r.operation = OP_DELETE;
    else if (pick < 90) r.operation = OP_READ_AT;
    else if (pick < 93) r.operation = OP_CLEAR;
    else                r.operation = 3'($urandom_range(6, 7));
    return r;
  endfunction

  initial begin : stimulus
    req_t cmd;
    plan.push_back(row(OP_GET, 32'h0, 32'h0, 4'd0, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd0, ST_MISSING)));
    plan.push_back(row(OP_READ_AT, 32'h0, 32'h0, 4'd0, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd0, ST_MISSING)));
    plan.push_back(row(OP_DELETE, 32'hFFFF_FFFF, 32'h0, 4'd15, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd0, ST_MISSING)));
    plan.push_back(row(OP_SET, 32'h0, 32'hFFFF_FFFF, 4'd0, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd0, ST_MISSING)));
    plan.push_back(row(OP_WRITE, 32'h0, 32'hFFFF_FFFF, 4'd0, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd1, ST_OK)));
    plan.push_back(row(OP_WRITE, 32'hFFFF_FFFF, 32'h0, 4'd15, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd2, ST_OK)));
    plan.push_back(row(OP_GET, 32'h0, 32'h0, 4'd0, 1, 1,
                       outcome(1'b1, 32'h0, 32'hFFFF_FFFF, 5'd2, ST_OK)));
    plan.push_back(row(OP_READ_AT, 32'h0, 32'h0, 4'd1, 1, 1,
                       outcome(1'b1, 32'hFFFF_FFFF, 32'h0, 5'd2, ST_OK)));
    plan.push_back(row(OP_WRITE, 32'h0, 32'h5A5A_5A5A, 4'd0, 1, 1,
                       outcome(1'b1, 32'h0, 32'h0, 5'd2, ST_OK)));
    plan.push_back(row(OP_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 4'd0, 1, 1,
                       outcome(1'b1, 32'h0, 32'h0, 5'd2, ST_OK)));
    plan.push_back(row(OP_DELETE, 32'h0, 32'h0, 4'd0, 1, 1,
                       outcome(1'b1, 32'h0, 32'h0, 5'd1, ST_OK)));
    plan.push_back(row(OP_READ_AT, 32'h0, 32'h0, 4'd0, 1, 1,
                       outcome(1'b1, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 5'd1, ST_OK)));
    plan.push_back(row(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd1, ST_OK)));
    plan.push_back(row(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd1, ST_OK)));
    plan.push_back(row(OP_CLEAR, 32'h0, 32'h0, 4'd0, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd0, ST_OK)));
    plan.push_back(row(OP_WRITE, 32'h100, 32'h1234_5678, 4'd0, CAPACITY, 0, '0));
    plan.push_back(row(OP_WRITE, 32'hDEAD_BEEF, 32'h7, 4'd0, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd16, ST_FULL)));
    plan.push_back(row(OP_READ_AT, 32'h0, 32'h0, 4'd15, 1, 0, '0));
    plan.push_back(row(OP_DELETE, 32'h100, 32'h0, 4'd0, 1, 1,
                       outcome(1'b1, 32'h0, 32'h0, 5'd15, ST_OK)));
    plan.push_back(row(OP_READ_AT, 32'h0, 32'h0, 4'd15, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd15, ST_MISSING)));
    plan.push_back(row(OP_WRITE, 32'hDEAD_BEEF, 32'h7, 4'd0, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd16, ST_OK)));
    plan.push_back(row(OP_READ_AT, 32'h0, 32'h0, 4'd15, 1, 0, '0));
    plan.push_back(row(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1, 1,
                       outcome(1'b0, 32'h0, 32'h0, 5'd0, ST_OK)));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) begin
        cmd = plan[i].cmd;
        cmd.key = cmd.key + n;
        send(cmd, plan[i].fixed, plan[i].want);
      end
    end

    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % 250 == 0) begin
        foreach (key_pool[k]) key_pool[k] = $urandom();
      end
      if (n == 650) wait_drained();
      gaps_on   = !(n >= 300 && n < 550);
      stalls_on = !(n >= 300 && n < 550);
      send(random_cmd(), 1'b0, '0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/okvt_pkg.sv
rtl/okvt_cell.sv
rtl/ordered_key_value_table.sv
verif/testbench.sv
